### hdl/cwsp_pkg.sv
`default_nettype none
package cwsp_pkg;

  localparam int MAX_PIECES = 1024;
  localparam int PIECE_BITS = 10;
  localparam int IDX_W      = $clog2(MAX_PIECES);
  localparam int CNT_W      = $clog2(MAX_PIECES + 1);
  localparam int TARGET_W   = 21;
  localparam int COUNT_W    = 11;
  localparam int CFG_W      = 21;
  localparam int SUM_W      = (PIECE_BITS + CNT_W > TARGET_W) ? PIECE_BITS + CNT_W : TARGET_W;
  localparam int HCNT_W     = 2 * CNT_W;
  localparam int HIST_DEPTH = 1 << TARGET_W;
  localparam int WAY_W      = 32;

  typedef enum logic [1:0] {
    CFG_TARGET  = 2'd0,
    CFG_COUNT_A = 2'd1,
    CFG_COUNT_B = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_SUM,
    ST_UPDATE,
    ST_TAIL_RD,
    ST_TAIL_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                  operation;
    logic [PIECE_BITS-1:0] piece_size;
  } req_t;

  typedef struct packed {
    logic [WAY_W-1:0] way_count;
    logic             saturated;
  } res_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic sum;
    logic update;
    logic tail_rd;
    logic tail_add;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic clr_last;
    logic over;
    logic run_end;
    logic last_start;
    logic phase_b;
  } stat_t;

  // count register to working length: zero acts as one, clamp at capacity
  function automatic logic [CNT_W-1:0] eff_count(input logic [COUNT_W-1:0] r);
    logic [31:0] v;
    v = 32'(r);
    if (v == 32'd0) v = 32'd1;
    else if (v > 32'(MAX_PIECES)) v = 32'(MAX_PIECES);
    return CNT_W'(v);
  endfunction

endpackage
`default_nettype wire

### hdl/cwsp_ram.sv
`default_nettype none
module cwsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/cwsp_ctrl.sv
`default_nettype none
module cwsp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               res_valid_o,
  input  wire cwsp_pkg::stat_t stat_i,
  output cwsp_pkg::cmd_t     cmd_o
);
  import cwsp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy        = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          if (stat_i.trigger) state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_SUM;
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        if (!stat_i.over) state_d = ST_UPDATE;
        else if (stat_i.last_start && !stat_i.phase_b) state_d = ST_TAIL_RD;
        else state_d = ST_FETCH;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (stat_i.run_end && stat_i.last_start && !stat_i.phase_b) state_d = ST_TAIL_RD;
        else state_d = ST_FETCH;
      end
      ST_TAIL_RD: begin
        cmd_o.tail_rd = 1'b1;
        state_d = ST_TAIL_ADD;
      end
      ST_TAIL_ADD: begin
        cmd_o.tail_add = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/cwsp_dpath.sv
`default_nettype none
module cwsp_dpath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [cwsp_pkg::CFG_W-1:0] cfg_data_i,
  input  wire cwsp_pkg::req_t         req_i,
  input  wire cwsp_pkg::cmd_t         cmd_i,
  output cwsp_pkg::stat_t             stat_o,
  output cwsp_pkg::res_t              res_o
);
  import cwsp_pkg::*;

  logic [TARGET_W-1:0] target_q;
  logic [COUNT_W-1:0]  cnt_a_q, cnt_b_q;
  logic [CNT_W-1:0]    loaded_a_q, loaded_a_d, loaded_b_q, loaded_b_d;
  logic [IDX_W-1:0]    start_q, start_d, ptr_q, ptr_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [TARGET_W-1:0] clr_q, clr_d;
  logic [WAY_W-1:0]    acc_q, acc_d;
  logic                phase_b_q, phase_b_d;

  logic [CNT_W-1:0]      na, nb, len, kmax, lb_new;
  logic [IDX_W-1:0]      len_m1;
  logic [PIECE_BITS-1:0] a_rdata, b_rdata, piece;
  logic [HCNT_W-1:0]     h_rdata, h_wdata;
  logic [TARGET_W-1:0]   h_raddr, h_waddr;
  logic [SUM_W-1:0]      s_new, t_ext, t_minus;
  logic                  h_we, a_we, b_we, b_store, over, end_start;

  function automatic logic [WAY_W-1:0] sat_add(input logic [WAY_W-1:0] a,
                                               input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WAY_W] ? '1 : s[WAY_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_W'(1);
      cnt_a_q  <= COUNT_W'(1);
      cnt_b_q  <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET:  target_q <= cfg_data_i[TARGET_W-1:0];
        CFG_COUNT_A: cnt_a_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_COUNT_B: cnt_b_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_a_q <= '0;
      loaded_b_q <= '0;
      acc_q      <= '0;
      phase_b_q  <= 1'b0;
    end else begin
      loaded_a_q <= loaded_a_d;
      loaded_b_q <= loaded_b_d;
      acc_q      <= acc_d;
      phase_b_q  <= phase_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    ptr_q   <= ptr_d;
    k_q     <= k_d;
    sum_q   <= sum_d;
    clr_q   <= clr_d;
  end

  assign na      = eff_count(cnt_a_q);
  assign nb      = eff_count(cnt_b_q);
  assign len     = phase_b_q ? nb : na;
  assign len_m1  = IDX_W'(len - CNT_W'(1));
  assign kmax    = (start_q == '0) ? len : len - CNT_W'(1);
  assign piece   = phase_b_q ? b_rdata : a_rdata;
  assign s_new   = sum_q + SUM_W'(piece);
  assign t_ext   = SUM_W'(target_q);
  assign over    = s_new > t_ext;
  assign t_minus = t_ext - s_new;
  assign b_store = loaded_b_q < nb;
  assign lb_new  = loaded_b_q + CNT_W'(b_store);

  assign a_we = cmd_i.accept && !req_i.operation && (loaded_a_q < na);
  assign b_we = cmd_i.accept && req_i.operation && b_store;

  assign stat_o.trigger    = req_i.operation && (lb_new >= nb);
  assign stat_o.clr_last   = clr_q == target_q;
  assign stat_o.over       = over;
  assign stat_o.run_end    = k_q == kmax;
  assign stat_o.last_start = start_q == len_m1;
  assign stat_o.phase_b    = phase_b_q;

  assign end_start = (cmd_i.sum && over) || (cmd_i.update && stat_o.run_end);

  // histogram of circle B sums: cleared up to target, then bumped per run
  assign h_we    = cmd_i.clear || (cmd_i.update && phase_b_q);
  assign h_waddr = cmd_i.clear ? clr_q : sum_q[TARGET_W-1:0];
  assign h_wdata = cmd_i.clear ? '0 : h_rdata + HCNT_W'(1);
  assign h_raddr = cmd_i.tail_rd ? target_q :
                   (phase_b_q ? s_new[TARGET_W-1:0] : t_minus[TARGET_W-1:0]);

  always_comb begin
    loaded_a_d = loaded_a_q;
    loaded_b_d = loaded_b_q;
    start_d    = start_q;
    ptr_d      = ptr_q;
    k_d        = k_q;
    sum_d      = sum_q;
    clr_d      = clr_q;
    acc_d      = acc_q;
    phase_b_d  = phase_b_q;

    if (cmd_i.accept) begin
      if (a_we) loaded_a_d = loaded_a_q + CNT_W'(1);
      if (req_i.operation) begin
        loaded_b_d = lb_new;
        if (stat_o.trigger) begin
          loaded_a_d = '0;
          loaded_b_d = '0;
          clr_d      = '0;
          acc_d      = '0;
          phase_b_d  = 1'b1;
          start_d    = '0;
          ptr_d      = '0;
          k_d        = '0;
          sum_d      = '0;
        end
      end
    end

    if (cmd_i.clear) clr_d = clr_q + TARGET_W'(1);

    if (cmd_i.sum && !over) begin
      sum_d = s_new;
      k_d   = k_q + CNT_W'(1);
      ptr_d = (ptr_q == len_m1) ? '0 : ptr_q + IDX_W'(1);
    end

    if (cmd_i.update && !phase_b_q)
      acc_d = sat_add(acc_q, WAY_W'(h_rdata) + WAY_W'(sum_q == t_ext));

    if (end_start) begin
      if (!stat_o.last_start) begin
        start_d = start_q + IDX_W'(1);
        ptr_d   = start_q + IDX_W'(1);
        k_d     = '0;
        sum_d   = '0;
      end else if (phase_b_q) begin
        phase_b_d = 1'b0;
        start_d   = '0;
        ptr_d     = '0;
        k_d       = '0;
        sum_d     = '0;
      end
    end

    if (cmd_i.tail_add) acc_d = sat_add(acc_q, WAY_W'(h_rdata));
  end

  assign res_o.way_count = acc_q;
  assign res_o.saturated = &acc_q;

  cwsp_ram #(.Width(PIECE_BITS), .Depth(MAX_PIECES)) u_store_a (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(loaded_a_q[IDX_W-1:0]),
    .wdata_i(req_i.piece_size),
    .raddr_i(ptr_q),
    .rdata_o(a_rdata)
  );

  cwsp_ram #(.Width(PIECE_BITS), .Depth(MAX_PIECES)) u_store_b (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(loaded_b_q[IDX_W-1:0]),
    .wdata_i(req_i.piece_size),
    .raddr_i(ptr_q),
    .rdata_o(b_rdata)
  );

  cwsp_ram #(.Width(HCNT_W), .Depth(HIST_DEPTH)) u_hist (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );
endmodule
`default_nettype wire

### hdl/circular_window_sum_pair_counter.sv
// Circular window sum pair counter.
// Requests arrive on start/req_i while busy is low: operation 0 loads the
// next piece of circle A, operation 1 the next piece of circle B. Loading
// takes one request per cycle. The B request that fills circle B (per
// count_b) raises busy and starts the counting pass; once it ends one
// result is shown on res_o with res_valid_o high for a single cycle, then
// busy drops. The receiver cannot stall and must take it then.
// Counting pass: clearing the sum histogram from 0 up to target_sum, then
// fetch, add and histogram update per run whose sum stays within target
// and fetch and add per start whose run first overshoots, over circle B
// then circle A, then tail lookup and result. These steps are set by
// the registered-read piece stores and the histogram read-modify-write.
// Run sums of B are binned in a 2^21-entry histogram; each A run then
// looks up its complement, so pairs are never enumerated directly.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) land at once and
// should only be made while busy is low and no load is part done.
// Reset clears load counts and result; registers return to 1, 1, 1.
`default_nettype none
module circular_window_sum_pair_counter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire cwsp_pkg::req_t             req_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [cwsp_pkg::CFG_W-1:0] cfg_data_i,
  output logic                            res_valid_o,
  output cwsp_pkg::res_t                  res_o
);
  import cwsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: load, clear, run walk, tail lookup, emit
  cwsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores, histogram, run counters and saturating accumulator
  cwsp_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (res_o)
  );
endmodule
`default_nettype wire

### tb/tb_circular_window_sum_pair_counter.sv
`default_nettype none
module tb_circular_window_sum_pair_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import cwsp_pkg::*;

  // piece tags on req.operation
  localparam logic OP_A = 1'b0;
  localparam logic OP_B = 1'b1;
  // longest counting pass: full target clear plus every run of two full
  // circles of zero pieces, with a wide margin
  localparam int unsigned IDLE_LIMIT = 30_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             res_valid_o;
  res_t             res_o;

  circular_window_sum_pair_counter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // local copy of block state
  logic [TARGET_W-1:0]   target_q;
  logic [COUNT_W-1:0]    count_a_q;
  logic [COUNT_W-1:0]    count_b_q;
  logic [PIECE_BITS-1:0] pieces_a [MAX_PIECES];
  logic [PIECE_BITS-1:0] pieces_b [MAX_PIECES];
  int unsigned           loaded_a;
  int unsigned           loaded_b;

  res_t        pending_counts [$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned counts_seen;
  int unsigned sat_seen;
  int unsigned idle_pct;
  int unsigned idle_cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned working_len(input logic [COUNT_W-1:0] r);
    if (r == '0) return 1;
    if (r > MAX_PIECES) return MAX_PIECES;
    return r;
  endfunction

  // histogram of arc sums (up to limit) for one circle; whole circle once
  function automatic void arc_sums(input logic [PIECE_BITS-1:0] p [MAX_PIECES],
                                   input int unsigned len, input int unsigned limit,
                                   ref longint unsigned hist [int unsigned]);
    int unsigned s;
    int unsigned whole;
    hist.delete();
    whole = 0;
    for (int unsigned i = 0; i < len; i++) begin
      s = 0;
      for (int unsigned k = 1; k < len; k++) begin
        s += p[(i + k - 1) % len];
        if (s > limit) break;
        if (hist.exists(s)) hist[s]++;
        else hist[s] = 1;
      end
      whole += p[i];
    end
    if (whole <= limit) begin
      if (hist.exists(whole)) hist[whole]++;
      else hist[whole] = 1;
    end
  endfunction

  function automatic res_t way_count_of();
    longint unsigned ha [int unsigned];
    longint unsigned hb [int unsigned];
    longint unsigned total;
    int unsigned     t;
    res_t            r;
    t = target_q;
    arc_sums(pieces_a, working_len(count_a_q), t, ha);
    arc_sums(pieces_b, working_len(count_b_q), t, hb);
    total = 0;
    if (ha.exists(t)) total += ha[t];
    if (hb.exists(t)) total += hb[t];
    foreach (ha[s]) if (hb.exists(t - s)) total += ha[s] * hb[t - s];
    r.saturated = (total >= 64'hFFFF_FFFF);
    r.way_count = r.saturated ? 32'hFFFF_FFFF : total[31:0];
    return r;
  endfunction

  // update local state for one accepted request
  function automatic void load_piece(input req_t r);
    int unsigned na;
    int unsigned nb;
    na = working_len(count_a_q);
    nb = working_len(count_b_q);
    if (r.operation == OP_A) begin
      if (loaded_a < na) begin
        pieces_a[loaded_a] = r.piece_size;
        loaded_a++;
      end
    end else begin
      if (loaded_b < nb) begin
        pieces_b[loaded_b] = r.piece_size;
        loaded_b++;
      end
      if (loaded_b >= nb) begin
        pending_counts.push_back(way_count_of());
        loaded_a = 0;
        loaded_b = 0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // results: one cycle each, no back-pressure
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d", res_o.way_count));
      end else begin
        want = pending_counts.pop_front();
        counts_seen++;
        if (want.saturated) sat_seen++;
        if (res_o.way_count !== want.way_count)
          report_mismatch($sformatf("way_count %0d, want %0d",
                                    res_o.way_count, want.way_count));
        if (res_o.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, want %0b",
                                    res_o.saturated, want.saturated));
      end
    end
  end

  // watchdog on cycles with no request or result
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [PIECE_BITS-1:0] size);
    start           <= 1'b1;
    req_i.operation <= op;
    req_i.piece_size <= size;
    do @(posedge clk_i); while (busy);
    load_piece('{operation: op, piece_size: size});
    requests_sent++;
    // each following cycle idles with probability idle_pct
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_TARGET:  target_q  = value[TARGET_W-1:0];
      CFG_COUNT_A: count_a_q = value[COUNT_W-1:0];
      CFG_COUNT_B: count_b_q = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned t, input int unsigned ca, input int unsigned cb);
    settle();
    write_reg(CFG_TARGET, CFG_W'(t));
    write_reg(CFG_COUNT_A, CFG_W'(ca));
    write_reg(CFG_COUNT_B, CFG_W'(cb));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PIECE_BITS-1:0] pick_size(input int unsigned hi);
    // mostly small so sums hit the target; full range now and then
    if ($urandom_range(9) == 0) return PIECE_BITS'($urandom());
    return PIECE_BITS'($urandom_range(hi));
  endfunction

  // one full pair: A pieces and all but the last B merged, stray A, final B
  task automatic load_pair(input int unsigned hi, input int unsigned extra_a);
    int unsigned na;
    int unsigned nb;
    int unsigned a_left;
    int unsigned b_left;
    na = working_len(count_a_q);
    nb = working_len(count_b_q);
    a_left = na;
    b_left = nb - 1;
    while (a_left + b_left != 0) begin
      if (b_left == 0 || (a_left != 0 && $urandom_range(1) == 0)) begin
        send_request(OP_A, pick_size(hi));
        a_left--;
      end else begin
        send_request(OP_B, pick_size(hi));
        b_left--;
      end
    end
    repeat (extra_a) send_request(OP_A, pick_size(hi));
    send_request(OP_B, pick_size(hi));
  endtask

  task automatic load_fixed(input logic [PIECE_BITS-1:0] size);
    repeat (working_len(count_a_q)) send_request(OP_A, size);
    repeat (working_len(count_b_q)) send_request(OP_B, size);
  endtask

  // registers still at their reset values
  task automatic test_reset_values();
    send_request(OP_A, 10'd1);
    send_request(OP_B, 10'd1);
  endtask

  // field extremes, count clamping and ignored A pieces
  task automatic test_extremes();
    configure(0, 2, 2);
    load_fixed('0);
    configure(2097151, 2, 1);
    load_fixed(10'h3FF);
    configure(2046, 2, 2);
    load_fixed(10'h3FF);
    configure(3, 0, 3);
    load_pair(3, 3);
    configure(0, 3, 1);
    send_request(OP_A, 10'h2AA);
    send_request(OP_A, 10'h155);
    send_request(OP_A, 10'h000);
    send_request(OP_B, 10'h3FF);
  endtask

  // largest circle via an over-range count register
  task automatic test_full_circle();
    configure(6, 2047, 8);
    load_pair(3, 0);
  endtask

  // zero pieces with zero target drive the count past 32 bits
  task automatic test_saturation();
    configure(0, 257, 257);
    load_fixed('0);
  endtask

  task automatic test_random(input int unsigned pct, input int unsigned quota);
    int unsigned stop_at;
    idle_pct = pct;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      configure($urandom_range(9) == 0 ? $urandom_range(2097151, 0) % 4000
                                      : $urandom_range(60),
                $urandom_range(9) == 0 ? $urandom_range(2047) % 40
                                      : $urandom_range(8, 1),
                $urandom_range(9) == 0 ? $urandom_range(2047) % 20
                                      : $urandom_range(8, 1));
      load_pair($urandom_range(1) ? 15 : 3, $urandom_range(3) == 0 ? $urandom_range(2) : 0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TARGET;
    cfg_data_i = '0;
    target_q = 1;
    count_a_q = 1;
    count_b_q = 1;
    loaded_a = 0;
    loaded_b = 0;
    mismatches = 0;
    requests_sent = 0;
    counts_seen = 0;
    sat_seen = 0;
    idle_pct = 0;
    idle_cycles = 0;
    foreach (pieces_a[i]) begin
      pieces_a[i] = '0;
      pieces_b[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_extremes();
    test_full_circle();
    test_saturation();
    test_random(0, 150);
    test_random(71, 150);
    test_random(26, 150);
    settle();

    $display("Covered %0d requests, %0d counts checked (%0d saturated),",
             requests_sent, counts_seen, sat_seen);
    $display("across target/count extremes and three sender idling mixes.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/cwsp_pkg.sv
hdl/cwsp_ram.sv
hdl/cwsp_ctrl.sv
hdl/cwsp_dpath.sv
hdl/circular_window_sum_pair_counter.sv
tb/tb_circular_window_sum_pair_counter.sv
